@@ src/tdr_pkg.sv @@
// Shared types and codes for the transmit descriptor ring.
// No dependencies; imported by the control, status memory and top modules.
`default_nettype none

package tdr_pkg;

    localparam int DEFAULT_SLOTS = 16;

    localparam int KIND_W  = 2;
    localparam int SLOT_W  = 4;
    localparam int COUNT_W = 4;

    typedef logic [KIND_W-1:0] kind_t;

    localparam kind_t KIND_RESERVE  = 2'd0;
    localparam kind_t KIND_FINALIZE = 2'd1;
    localparam kind_t KIND_START    = 2'd2;
    localparam kind_t KIND_POP      = 2'd3;

    typedef logic [1:0] status_t;

    localparam status_t ST_ALLOCATED    = 2'd0;
    localparam status_t ST_COMPLETE     = 2'd1;
    localparam status_t ST_TRANSMITTING = 2'd2;

    // Strobes and write data from the control unit to the status memory.
    typedef struct packed {
        logic    wr_en;
        logic    rd_en;
        status_t wr_data;
    } mem_ctl_t;

endpackage

`default_nettype wire

@@ src/tdr_status_mem.sv @@
// Slot status memory: one write port, one read port, registered read data.
// Depends on tdr_pkg.
`default_nettype none

module tdr_status_mem
    import tdr_pkg::*;
#(
    parameter int SLOTS = DEFAULT_SLOTS,
    parameter int PTR_W = $clog2(SLOTS)
)
(
    input  wire logic             clk,
    input  wire mem_ctl_t         ctl,
    input  wire logic [PTR_W-1:0] wr_addr,
    input  wire logic [PTR_W-1:0] rd_addr,
    output      status_t          rd_data
);

    status_t status_mem [SLOTS];
    status_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            status_mem[wr_addr] <= ctl.wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= status_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ src/tdr_ctrl.sv @@
// Ring control: head/tail pointers, cached head status, request decode and
// the result register. Drives tdr_status_mem. Depends on tdr_pkg.
`default_nettype none

module tdr_ctrl
    import tdr_pkg::*;
#(
    parameter int SLOTS = DEFAULT_SLOTS,
    parameter int PTR_W = $clog2(SLOTS)
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output      logic               in_ready,
    input  wire kind_t              kind,
    input  wire logic [SLOT_W-1:0]  slot_in,
    output      logic               out_valid,
    input  wire logic               out_ready,
    output      logic               ok,
    output      logic [SLOT_W-1:0]  slot_out,
    output      logic               pending,
    output      logic [COUNT_W-1:0] count,
    output      mem_ctl_t           mem_ctl,
    output      logic [PTR_W-1:0]   mem_wr_addr,
    output      logic [PTR_W-1:0]   mem_rd_addr,
    input  wire status_t            mem_rd_data
);

    localparam int CNT_W = PTR_W + 1;
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(SLOTS - 1);

    localparam logic S_IDLE     = 1'b0;
    localparam logic S_POP_WAIT = 1'b1;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == LAST_SLOT) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [COUNT_W-1:0] ring_count(input logic [PTR_W-1:0] h,
                                                      input logic [PTR_W-1:0] t);
        logic [CNT_W-1:0] d;
        d = {1'b0, t} - {1'b0, h};
        if (t < h)
        begin
            d = d + CNT_W'(SLOTS);
        end
        return COUNT_W'(d);
    endfunction

    logic             state_reg,  state_next;
    logic [PTR_W-1:0] head_reg,   head_next;
    logic [PTR_W-1:0] tail_reg,   tail_next;
    status_t          hstat_reg,  hstat_next;   // status of the slot at head
    logic             out_valid_reg, out_valid_next;

    logic               ok_reg;
    logic [SLOT_W-1:0]  slot_out_reg;
    logic               pending_reg;
    logic [COUNT_W-1:0] count_reg;

    logic             accept;
    logic             res_load;
    logic             res_ok;
    logic [PTR_W-1:0] res_slot;
    logic [PTR_W-1:0] fin_idx;
    logic             fin_in_range;
    logic             not_empty;

    assign in_ready     = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign accept       = in_valid && in_ready;
    assign fin_idx      = PTR_W'(slot_in);
    assign fin_in_range = {28'd0, slot_in} < 32'(SLOTS);
    assign not_empty    = (head_reg != tail_reg);

    always_comb
    begin
        state_next          = state_reg;
        head_next           = head_reg;
        tail_next           = tail_reg;
        hstat_next          = hstat_reg;
        res_load            = 1'b0;
        res_ok              = 1'b0;
        res_slot            = '0;
        mem_ctl.wr_en       = 1'b0;
        mem_ctl.rd_en       = 1'b0;
        mem_ctl.wr_data     = ST_ALLOCATED;
        mem_wr_addr         = tail_reg;
        mem_rd_addr         = ptr_inc(head_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_load = 1'b1;
                    unique case (kind)
                        KIND_RESERVE:
                        begin
                            if (ptr_inc(tail_reg) != head_reg)
                            begin
                                mem_ctl.wr_en   = 1'b1;
                                mem_ctl.wr_data = ST_ALLOCATED;
                                mem_wr_addr     = tail_reg;
                                if (tail_reg == head_reg)
                                begin
                                    hstat_next = ST_ALLOCATED;
                                end
                                tail_next = ptr_inc(tail_reg);
                                res_ok    = 1'b1;
                                res_slot  = tail_reg;
                            end
                        end
                        KIND_FINALIZE:
                        begin
                            if (fin_in_range)
                            begin
                                mem_ctl.wr_en   = 1'b1;
                                mem_ctl.wr_data = ST_COMPLETE;
                                mem_wr_addr     = fin_idx;
                                if (fin_idx == head_reg)
                                begin
                                    hstat_next = ST_COMPLETE;
                                end
                                res_ok = 1'b1;
                            end
                        end
                        KIND_START:
                        begin
                            if (not_empty && hstat_reg == ST_COMPLETE)
                            begin
                                mem_ctl.wr_en   = 1'b1;
                                mem_ctl.wr_data = ST_TRANSMITTING;
                                mem_wr_addr     = head_reg;
                                hstat_next      = ST_TRANSMITTING;
                                res_ok          = 1'b1;
                                res_slot        = head_reg;
                            end
                        end
                        KIND_POP:
                        begin
                            if (not_empty && hstat_reg != ST_ALLOCATED)
                            begin
                                // new head status comes back from memory next cycle
                                mem_ctl.rd_en = 1'b1;
                                mem_rd_addr   = ptr_inc(head_reg);
                                head_next     = ptr_inc(head_reg);
                                res_load      = 1'b0;
                                state_next    = S_POP_WAIT;
                            end
                        end
                        default:
                        begin
                            res_load = 1'b1;
                        end
                    endcase
                end
            end
            S_POP_WAIT:
            begin
                hstat_next = mem_rd_data;
                res_load   = 1'b1;
                res_ok     = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            hstat_reg     <= ST_ALLOCATED;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            hstat_reg     <= hstat_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, computed from the state after the request
    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            ok_reg       <= res_ok;
            slot_out_reg <= SLOT_W'(res_slot);
            pending_reg  <= (head_next != tail_next) && (hstat_next == ST_COMPLETE);
            count_reg    <= ring_count(head_next, tail_next);
        end
    end

    assign out_valid = out_valid_reg;
    assign ok        = ok_reg;
    assign slot_out  = slot_out_reg;
    assign pending   = pending_reg;
    assign count     = count_reg;

endmodule

`default_nettype wire

@@ src/tx_descriptor_ring_top.sv @@
// Transmit descriptor ring, top level.
// Requests arrive on the in_valid/in_ready channel (kind, slot_in); every
// request yields exactly one result on out_valid/out_ready
// (ok, slot_out, pending, count).
// Kinds: reserve takes the tail slot, finalize marks slot_in complete,
// start marks a complete head slot transmitting, pop advances the head.
// The ring holds at most SLOTS-1 entries; one slot always stays empty.
// Reserve, finalize and start give their result in the cycle after the
// request is taken. A pop that succeeds reads the new head slot's status
// from the status memory's read data register before it loads the result.
// One request is in work at a time: the rate is one request per cycle while
// results are taken, and a successful pop holds off the next request.
// The result sits in an output register; the next request is taken in the
// same cycle the pending result is taken. While the receiver stalls, the
// result is held and in_ready stays low.
// Reset empties the ring (head = tail = 0); slot status memory is not
// cleared and needs no clearing pass.
// Depends on tdr_pkg, tdr_ctrl and tdr_status_mem.
`default_nettype none

module tx_descriptor_ring_top
    import tdr_pkg::*;
#(
    parameter int SLOTS = DEFAULT_SLOTS
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output      logic               in_ready,
    input  wire logic [KIND_W-1:0]  kind,
    input  wire logic [SLOT_W-1:0]  slot_in,
    output      logic               out_valid,
    input  wire logic               out_ready,
    output      logic               ok,
    output      logic [SLOT_W-1:0]  slot_out,
    output      logic               pending,
    output      logic [COUNT_W-1:0] count
);

    localparam int PTR_W = $clog2(SLOTS);

    mem_ctl_t         mem_ctl;
    logic [PTR_W-1:0] mem_wr_addr;
    logic [PTR_W-1:0] mem_rd_addr;
    status_t          mem_rd_data;

    tdr_ctrl #(
        .SLOTS (SLOTS),
        .PTR_W (PTR_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind_t'(kind)),
        .slot_in     (slot_in),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .ok          (ok),
        .slot_out    (slot_out),
        .pending     (pending),
        .count       (count),
        .mem_ctl     (mem_ctl),
        .mem_wr_addr (mem_wr_addr),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    tdr_status_mem #(
        .SLOTS (SLOTS),
        .PTR_W (PTR_W)
    ) u_status_mem (
        .clk     (clk),
        .ctl     (mem_ctl),
        .wr_addr (mem_wr_addr),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
// Testbench for the transmit descriptor ring: directed requests from a table,
// then random request traffic, each result checked against the table or an in-bench ring model.
// Depends on tdr_pkg and tx_descriptor_ring_top.

module tb
    import tdr_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_SLOTS     = DEFAULT_SLOTS;
    localparam int RANDOM_ITEMS   = 920;
    localparam int QUIET_LIMIT    = 2000;
    localparam int HOLD_AT        = 300;
    localparam int HOLD_LEN       = 200;
    localparam int RX_CALM_FROM   = 900;
    localparam int RX_CALM_TO     = 1300;
    localparam int TX_CALM_FROM   = 450;
    localparam int TX_CALM_TO     = 650;
    localparam int DRAIN_CYCLES   = 4;

    typedef struct packed {
        logic               ok;
        logic [SLOT_W-1:0]  slot;
        logic               pending;
        logic [COUNT_W-1:0] count;
    } outcome_t;

    typedef struct packed {
        kind_t             k;
        logic [SLOT_W-1:0] s;
        logic [4:0]        reps;
        logic              typed;
        outcome_t          exp;
    } stim_row_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    kind_t              kind;
    logic [SLOT_W-1:0]  slot_in;
    logic               out_valid;
    logic               out_ready;
    logic               ok;
    logic [SLOT_W-1:0]  slot_out;
    logic               pending;
    logic [COUNT_W-1:0] count;

    // ring model state, owned by the sender process
    int       head_p;
    int       tail_p;
    status_t  slot_state [RING_SLOTS];

    outcome_t outcome_q [$];
    int       mismatches = 0;
    int       item_no = 0;

    // Walk through: empty-ring rejects, finalize of a slot outside the ring,
    // reserve/finalize/start/pop of one entry, then fill to full and pop.
    stim_row_t opening_requests [15] = '{
        '{KIND_POP,      4'd0,  5'd1,  1'b1, '{1'b0, 4'd0,  1'b0, 4'd0}},
        '{KIND_START,    4'd0,  5'd1,  1'b1, '{1'b0, 4'd0,  1'b0, 4'd0}},
        '{KIND_FINALIZE, 4'd15, 5'd1,  1'b1, '{1'b1, 4'd0,  1'b0, 4'd0}},
        '{KIND_RESERVE,  4'd9,  5'd1,  1'b1, '{1'b1, 4'd0,  1'b0, 4'd1}},
        '{KIND_POP,      4'd0,  5'd1,  1'b1, '{1'b0, 4'd0,  1'b0, 4'd1}},
        '{KIND_START,    4'd0,  5'd1,  1'b1, '{1'b0, 4'd0,  1'b0, 4'd1}},
        '{KIND_FINALIZE, 4'd0,  5'd1,  1'b1, '{1'b1, 4'd0,  1'b1, 4'd1}},
        '{KIND_START,    4'd0,  5'd1,  1'b1, '{1'b1, 4'd0,  1'b0, 4'd1}},
        '{KIND_POP,      4'd0,  5'd1,  1'b1, '{1'b1, 4'd0,  1'b0, 4'd0}},
        '{KIND_RESERVE,  4'd0,  5'd14, 1'b0, '0},
        '{KIND_RESERVE,  4'd0,  5'd1,  1'b1, '{1'b1, 4'd15, 1'b0, 4'd15}},
        '{KIND_RESERVE,  4'd0,  5'd1,  1'b1, '{1'b0, 4'd0,  1'b0, 4'd15}},
        '{KIND_FINALIZE, 4'd1,  5'd1,  1'b1, '{1'b1, 4'd0,  1'b1, 4'd15}},
        '{KIND_POP,      4'd0,  5'd1,  1'b1, '{1'b1, 4'd0,  1'b0, 4'd14}},
        '{KIND_POP,      4'd0,  5'd1,  1'b1, '{1'b0, 4'd0,  1'b0, 4'd14}}
    };

    tx_descriptor_ring_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .slot_in   (slot_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .ok        (ok),
        .slot_out  (slot_out),
        .pending   (pending),
        .count     (count)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic logic head_pending();
        return head_p != tail_p && slot_state[head_p] == ST_COMPLETE;
    endfunction

    // Applies one request to the ring model and returns the result it gives.
    function automatic outcome_t ring_outcome(kind_t k, logic [SLOT_W-1:0] s);
        outcome_t o;
        int       nt;
        o = '0;
        case (k)
            KIND_RESERVE:
            begin
                nt = (tail_p + 1) % RING_SLOTS;
                if (nt != head_p)
                begin
                    slot_state[tail_p] = ST_ALLOCATED;
                    o.slot = SLOT_W'(tail_p);
                    tail_p = nt;
                    o.ok = 1'b1;
                end
            end
            KIND_FINALIZE:
            begin
                if (int'(s) < RING_SLOTS)
                begin
                    slot_state[s] = ST_COMPLETE;
                    o.ok = 1'b1;
                end
            end
            KIND_START:
            begin
                if (head_pending())
                begin
                    slot_state[head_p] = ST_TRANSMITTING;
                    o.slot = SLOT_W'(head_p);
                    o.ok = 1'b1;
                end
            end
            default:
            begin
                // complete and transmitting heads both pop
                if (head_p != tail_p && slot_state[head_p] != ST_ALLOCATED)
                begin
                    head_p = (head_p + 1) % RING_SLOTS;
                    o.ok = 1'b1;
                end
            end
        endcase
        o.pending = head_pending();
        o.count = COUNT_W'((tail_p + RING_SLOTS - head_p) % RING_SLOTS);
        return o;
    endfunction

    // Offers one request, waits for it to be taken, queues its expected result.
    task automatic send_request(kind_t k, logic [SLOT_W-1:0] s, logic typed,
                                outcome_t typed_exp);
        outcome_t predicted;
        if (!(item_no >= TX_CALM_FROM && item_no < TX_CALM_TO)
            && $urandom_range(0, 99) < 7)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        slot_in  <= s;
        do @(posedge clk); while (!in_ready);
        predicted = ring_outcome(k, s);
        outcome_q.push_back(typed ? typed_exp : predicted);
        item_no++;
    endtask

    initial
    begin : sender
        int                r;
        int                live;
        logic              filling;
        kind_t             k;
        logic [SLOT_W-1:0] s;

        in_valid <= 1'b0;
        kind     <= KIND_RESERVE;
        slot_in  <= '0;
        head_p = 0;
        tail_p = 0;
        foreach (slot_state[i])
            slot_state[i] = ST_ALLOCATED;

        wait (rst_n);
        @(posedge clk);

        foreach (opening_requests[i])
            for (int n = 0; n < opening_requests[i].reps; n++)
                send_request(opening_requests[i].k, opening_requests[i].s,
                             opening_requests[i].typed, opening_requests[i].exp);

        // Alternate fill-heavy and drain-heavy stretches so the ring swings
        // between empty and full.
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            filling = ((i / 48) % 2) == 0;
            r = $urandom_range(0, 99);
            if (r < (filling ? 45 : 15))
                k = KIND_RESERVE;
            else if (r < (filling ? 70 : 50))
                k = KIND_FINALIZE;
            else if (r < (filling ? 85 : 70))
                k = KIND_START;
            else
                k = KIND_POP;
            s = SLOT_W'($urandom_range(0, RING_SLOTS - 1));
            // mostly finalize live entries, the head above all
            if (k == KIND_FINALIZE && head_p != tail_p && $urandom_range(0, 99) < 65)
            begin
                live = (tail_p + RING_SLOTS - head_p) % RING_SLOTS;
                if ($urandom_range(0, 1))
                    s = SLOT_W'(head_p);
                else
                    s = SLOT_W'((head_p + $urandom_range(0, live - 1)) % RING_SLOTS);
            end
            send_request(k, s, 1'b0, '0);
        end

        in_valid <= 1'b0;
        while (outcome_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Result side: random stalls, one long hold to back up the input, and a
    // stretch with no stalls.
    initial
    begin : receiver
        int cyc;
        cyc = 0;
        out_ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (cyc >= HOLD_AT && cyc < HOLD_AT + HOLD_LEN)
                out_ready <= 1'b0;
            else if (cyc >= RX_CALM_FROM && cyc < RX_CALM_TO)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(0, 99) >= 7);
            @(posedge clk);
            cyc++;
        end
    end

    task automatic compare_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        outcome_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (outcome_q.size() == 0)
            begin
                $display("%0t: result with no request waiting, expected none, got %0d/%0d/%0d/%0d",
                         $time, ok, slot_out, pending, count);
                mismatches++;
            end
            else
            begin
                want = outcome_q.pop_front();
                compare_field("ok",       8'(want.ok),      8'(ok));
                compare_field("slot_out", 8'(want.slot),    8'(slot_out));
                compare_field("pending",  8'(want.pending), 8'(pending));
                compare_field("count",    8'(want.count),   8'(count));
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        wait (rst_n);
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no request or result moved for %0d cycles", $time, QUIET_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

endmodule
